@@ rtl/core/erpd_pkg.sv @@
// Shared widths, data types and step functions for the ellipse radial distance pipeline.
`default_nettype none
package erpd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int RAD_BITS   = 15;

  // Offsets, magnitudes and the result.
  localparam int DW    = COORD_BITS + 1;
  localparam int AW    = COORD_BITS;
  localparam int OUT_W = COORD_BITS + 1;

  // Sum of squares, weighted sum and the root widths.
  localparam int S_W    = 2 * AW + 1;
  localparam int R2_W   = 2 * RAD_BITS + 2 * AW + 1;
  localparam int ROOT_W = (R2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int L_W    = (S_W + 2 * FRAC_BITS + 1) / 2;
  localparam int ABQ_W  = 2 * RAD_BITS + FRAC_BITS;

  // Quotient of the ratio and the final product.
  localparam int Q_W    = RAD_BITS + FRAC_BITS + 2;
  localparam int DVD_W  = ROOT_W + FRAC_BITS;
  localparam int PROD_W = Q_W + L_W;

  // Register stages: front end, root cells, numerator, divider cells, multiply, output.
  localparam int FRONT_STG = 4;
  localparam int NSTG      = FRONT_STG + ROOT_W + 1 + Q_W + 2;

  // One bit step of an integer square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // Data that rides alongside the root cells.
  typedef struct packed {
    logic              special;
    logic [OUT_W-1:0]  sres;
    logic [ABQ_W-1:0]  abq;
  } side_t;

  // One bit step of the restoring divider.
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    quo;
    logic [ROOT_W-1:0] d;
  } dv_t;

  // Data that rides alongside the divider cells.
  typedef struct packed {
    logic              special;
    logic [OUT_W-1:0]  sres;
    logic [L_W-1:0]    lq;
    logic              rzero;
  } dside_t;

  // Bring down two radicand bits and decide one root bit.
  function automatic sq_t sq_step(sq_t x);
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] t;
    sq_t              y;
    rs    = {x.rem, x.rad[RAD_W-1 -: 2]};
    t     = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[RAD_W-3:0], 2'b00};
    if (rs >= t) begin
      y.rem  = REM_W'(rs - t);
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = rs[REM_W-1:0];
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  // Bring down one dividend bit and decide one quotient bit.
  function automatic dv_t dv_step(dv_t x);
    logic [ROOT_W:0] rs;
    dv_t             y;
    rs    = {x.rem, x.low[Q_W-1]};
    y.low = {x.low[Q_W-2:0], 1'b0};
    y.d   = x.d;
    if (rs >= {1'b0, x.d}) begin
      y.rem = ROOT_W'(rs - {1'b0, x.d});
      y.quo = {x.quo[Q_W-2:0], 1'b1};
    end else begin
      y.rem = rs[ROOT_W-1:0];
      y.quo = {x.quo[Q_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/erpd_front.sv @@
// Front end: offsets, squares, weighted products and the special axis cases.
`default_nettype none
module erpd_front (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic signed [erpd_pkg::AW-1:0] center_x_i,
  input  wire logic signed [erpd_pkg::AW-1:0] center_y_i,
  input  wire logic [erpd_pkg::RAD_BITS-1:0]  radius_x_i,
  input  wire logic [erpd_pkg::RAD_BITS-1:0]  radius_y_i,
  input  wire logic signed [erpd_pkg::AW-1:0] point_x_i,
  input  wire logic signed [erpd_pkg::AW-1:0] point_y_i,
  output logic [erpd_pkg::S_W-1:0]            s_o,
  output logic [erpd_pkg::R2_W-1:0]           r2_o,
  output erpd_pkg::side_t                     side_o
);

  // First stage: offsets from the centre.
  logic signed [erpd_pkg::DW-1:0]   dx_q, dy_q;
  logic [erpd_pkg::RAD_BITS-1:0]    a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= erpd_pkg::DW'(point_x_i) - erpd_pkg::DW'(center_x_i);
      dy_q <= erpd_pkg::DW'(point_y_i) - erpd_pkg::DW'(center_y_i);
      a_q  <= radius_x_i;
      b_q  <= radius_y_i;
    end
  end

  // Magnitudes and the axis-aligned answers.
  logic [erpd_pkg::DW-1:0]  ndx, ndy;
  logic [erpd_pkg::AW-1:0]  adx, ady;
  logic [erpd_pkg::OUT_W-1:0] ex, ey, ea, eb;

  always_comb begin
    ndx = erpd_pkg::DW'(-dx_q);
    ndy = erpd_pkg::DW'(-dy_q);
    adx = dx_q[erpd_pkg::DW-1] ? ndx[erpd_pkg::AW-1:0] : dx_q[erpd_pkg::AW-1:0];
    ady = dy_q[erpd_pkg::DW-1] ? ndy[erpd_pkg::AW-1:0] : dy_q[erpd_pkg::AW-1:0];
    ex  = erpd_pkg::OUT_W'(adx);
    ey  = erpd_pkg::OUT_W'(ady);
    ea  = erpd_pkg::OUT_W'(a_q);
    eb  = erpd_pkg::OUT_W'(b_q);
  end

  // Second stage: squares and the special cases.
  logic [2*erpd_pkg::AW-1:0]       sqx_q, sqy_q;
  logic [2*erpd_pkg::RAD_BITS-1:0] aa_q, bb_q, ab_q;
  logic                            spc_b_q;
  logic [erpd_pkg::OUT_W-1:0]      sres_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= adx * adx;
      sqy_q   <= ady * ady;
      aa_q    <= a_q * a_q;
      bb_q    <= b_q * b_q;
      ab_q    <= a_q * b_q;
      spc_b_q <= (dx_q == '0) || (dy_q == '0);
      if (dx_q == '0) begin
        sres_b_q <= (ey > eb) ? ey - eb : eb - ey;
      end else begin
        sres_b_q <= (ex > ea) ? ex - ea : ea - ex;
      end
    end
  end

  // Third stage: plain sum of squares and the two weighted terms.
  logic [erpd_pkg::S_W-1:0]   s_c_q;
  logic [erpd_pkg::R2_W-2:0]  px_q, py_q;
  erpd_pkg::side_t            side_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_c_q            <= erpd_pkg::S_W'(sqx_q) + erpd_pkg::S_W'(sqy_q);
      px_q             <= bb_q * sqx_q;
      py_q             <= aa_q * sqy_q;
      side_c_q.special <= spc_b_q;
      side_c_q.sres    <= sres_b_q;
      side_c_q.abq     <= {ab_q, {erpd_pkg::FRAC_BITS{1'b0}}};
    end
  end

  // Fourth stage: weighted sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o    <= s_c_q;
      r2_o   <= erpd_pkg::R2_W'(px_q) + erpd_pkg::R2_W'(py_q);
      side_o <= side_c_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/erpd_sqrt_cell.sv @@
// One cell of the root chain: a bit of both square roots per cycle while enabled.
`default_nettype none
module erpd_sqrt_cell (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire erpd_pkg::sq_t   l_i,
  input  wire erpd_pkg::sq_t   r_i,
  input  wire erpd_pkg::side_t side_i,
  output erpd_pkg::sq_t        l_o,
  output erpd_pkg::sq_t        r_o,
  output erpd_pkg::side_t      side_o
);

  // Step both roots and pass the side data to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_o    <= erpd_pkg::sq_step(l_i);
      r_o    <= erpd_pkg::sq_step(r_i);
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/erpd_div_cell.sv @@
// One cell of the divider chain: a quotient bit per cycle while enabled.
`default_nettype none
module erpd_div_cell (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire erpd_pkg::dv_t    dv_i,
  input  wire erpd_pkg::dside_t side_i,
  output erpd_pkg::dv_t         dv_o,
  output erpd_pkg::dside_t      side_o
);

  // Trial subtract and pass the side data on.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_o   <= erpd_pkg::dv_step(dv_i);
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ellipse_radial_point_distance.sv @@
// Throughput: one item per cycle unless a valid output is stalled; the root chain
// (one bit per cell) and the divider chain (one quotient bit per cell) are fully pipelined.
// A stalled output holds the whole pipeline in place.
// Reset clears only the valid bits; the datapath needs no reset.
`default_nettype none
module ellipse_radial_point_distance (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [erpd_pkg::AW-1:0]      center_x_i,
  input  wire logic signed [erpd_pkg::AW-1:0]      center_y_i,
  input  wire logic [erpd_pkg::RAD_BITS-1:0]       radius_x_i,
  input  wire logic [erpd_pkg::RAD_BITS-1:0]       radius_y_i,
  input  wire logic signed [erpd_pkg::AW-1:0]      point_x_i,
  input  wire logic signed [erpd_pkg::AW-1:0]      point_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [erpd_pkg::OUT_W-1:0]               distance_o
);

  // Pipeline advance and valid bits.
  logic                        en;
  logic [erpd_pkg::NSTG-1:0]   vld_q;

  assign en          = !vld_q[erpd_pkg::NSTG-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[erpd_pkg::NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[erpd_pkg::NSTG-2:0], in_valid_i};
    end
  end

  // Front end.
  logic [erpd_pkg::S_W-1:0]  s;
  logic [erpd_pkg::R2_W-1:0] r2;
  erpd_pkg::side_t           side_f;

  erpd_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_x_i (radius_x_i),
    .radius_y_i (radius_y_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .s_o        (s),
    .r2_o       (r2),
    .side_o     (side_f)
  );

  // Root chain: the length and the weighted radius in fixed point.
  erpd_pkg::sq_t   sl [0:erpd_pkg::ROOT_W];
  erpd_pkg::sq_t   sr [0:erpd_pkg::ROOT_W];
  erpd_pkg::side_t sd [0:erpd_pkg::ROOT_W];

  always_comb begin
    sl[0].rad  = erpd_pkg::RAD_W'({s, {(2*erpd_pkg::FRAC_BITS){1'b0}}});
    sl[0].rem  = '0;
    sl[0].root = '0;
    sr[0].rad  = erpd_pkg::RAD_W'({r2, {(2*erpd_pkg::FRAC_BITS){1'b0}}});
    sr[0].rem  = '0;
    sr[0].root = '0;
    sd[0]      = side_f;
  end

  for (genvar i = 0; i < erpd_pkg::ROOT_W; i++) begin : g_sq
    erpd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .l_i    (sl[i]),
      .r_i    (sr[i]),
      .side_i (sd[i]),
      .l_o    (sl[i+1]),
      .r_o    (sr[i+1]),
      .side_o (sd[i+1])
    );
  end

  // Numerator of the ratio and the divider set-up.
  logic [erpd_pkg::ROOT_W-1:0] rq, abq_e, num;
  logic [erpd_pkg::DVD_W-1:0]  dvd;
  erpd_pkg::dv_t               dv [0:erpd_pkg::Q_W];
  erpd_pkg::dside_t            ds [0:erpd_pkg::Q_W];

  always_comb begin
    rq    = sr[erpd_pkg::ROOT_W].root;
    abq_e = erpd_pkg::ROOT_W'(sd[erpd_pkg::ROOT_W].abq);
    num   = (rq >= abq_e) ? rq - abq_e : abq_e - rq;
    dvd   = {num, {erpd_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv[0].rem      <= erpd_pkg::ROOT_W'(dvd[erpd_pkg::DVD_W-1:erpd_pkg::Q_W]);
      dv[0].low      <= dvd[erpd_pkg::Q_W-1:0];
      dv[0].quo      <= '0;
      dv[0].d        <= rq;
      ds[0].special  <= sd[erpd_pkg::ROOT_W].special;
      ds[0].sres     <= sd[erpd_pkg::ROOT_W].sres;
      ds[0].lq       <= sl[erpd_pkg::ROOT_W].root[erpd_pkg::L_W-1:0];
      ds[0].rzero    <= (rq == '0);
    end
  end

  // Divider chain.
  for (genvar j = 0; j < erpd_pkg::Q_W; j++) begin : g_dv
    erpd_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .dv_i   (dv[j]),
      .side_i (ds[j]),
      .dv_o   (dv[j+1]),
      .side_o (ds[j+1])
    );
  end

  // Ratio times length; a zero weighted radius counts as ratio one.
  logic [erpd_pkg::Q_W-1:0]    q;
  logic [erpd_pkg::PROD_W-1:0] prod_q;
  logic                        spc_q;
  logic [erpd_pkg::OUT_W-1:0]  sres_q;

  always_comb begin
    q = dv[erpd_pkg::Q_W].quo;
    if (ds[erpd_pkg::Q_W].rzero) begin
      q = '0;
      q[erpd_pkg::FRAC_BITS] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= q * ds[erpd_pkg::Q_W].lq;
      spc_q  <= ds[erpd_pkg::Q_W].special;
      sres_q <= ds[erpd_pkg::Q_W].sres;
    end
  end

  // Output register with the special-case bypass and saturation.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (spc_q) begin
        distance_o <= sres_q;
      end else if (|prod_q[erpd_pkg::PROD_W-1:2*erpd_pkg::FRAC_BITS+erpd_pkg::OUT_W]) begin
        distance_o <= '1;
      end else begin
        distance_o <= prod_q[2*erpd_pkg::FRAC_BITS +: erpd_pkg::OUT_W];
      end
    end
  end

endmodule
`default_nettype wire
